[hw/rtl/afr_pkg.sv]
// Shared types, constants and the header byte table for the actuator frame receiver.
// No dependencies; imported by every afr_* module and the top level.
`default_nettype none

package afr_pkg;

	// Parameter defaults and limits
	localparam int HEADER_LENGTH_DEF = 5;
	localparam int RELAY_COUNT_DEF   = 4;
	localparam int HEADER_MAX        = 8;
	localparam int RELAY_MAX         = 8;

	// Frame layout
	localparam logic [7:0] MIN_DATA = 8'd5;
	localparam logic [7:0] COUNT_MAX = 8'hff;

	// Command and device codes
	localparam logic [7:0] CMD_TOGGLE = 8'h01;
	localparam logic [7:0] KIND_RELAY = 8'h01;
	localparam logic [7:0] KIND_FAN   = 8'h02;
	localparam logic [7:0] FAN_ON_REQ = 8'h00;

	localparam logic [7:0] ROOM_RESET = 8'h01;

	// Frame status codes
	localparam logic [2:0] ST_ACTED    = 3'd0;
	localparam logic [2:0] ST_HEADER   = 3'd1;
	localparam logic [2:0] ST_CHECKSUM = 3'd2;
	localparam logic [2:0] ST_LENGTH   = 3'd3;
	localparam logic [2:0] ST_ADDRESS  = 3'd4;
	localparam logic [2:0] ST_IGNORED  = 3'd5;

	typedef logic [HEADER_MAX-1:0][7:0] header_table_t;

	// Entry 0 sits in the low byte
	localparam header_table_t HEADER_BYTES = {
		8'h00, 8'h00, 8'h00, 8'h61, 8'h6b, 8'h75, 8'h73, 8'h41
	};

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_frame;
	} afr_in_t;

	typedef struct packed {
		logic [2:0] frame_status;
		logic [3:0] relay_states;
		logic [1:0] fan_states;
	} afr_out_t;

	// Stage 1 item as handed to the frame core
	typedef struct packed {
		logic    valid;
		afr_in_t item;
	} afr_stage_t;

endpackage

`default_nettype wire

[hw/rtl/afr_in_stage.sv]
// Input register of the actuator frame receiver: holds one byte transaction.
// Depends on afr_pkg.
`default_nettype none

module afr_in_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire afr_pkg::afr_in_t in_data,
	input  wire logic             advance,
	output logic                  in_stall,
	output afr_pkg::afr_stage_t   stage
);
	import afr_pkg::*;

	logic    valid_s1;
	afr_in_t data_s1;

	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			data_s1 <= in_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.item  = data_s1;

`ifndef SYNTH
	// a held item never vanishes while stalled
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1 && $stable(data_s1))
		else $error("stalled input item lost");
`endif

endmodule

`default_nettype wire

[hw/rtl/afr_frame_core.sv]
// Frame tracking state and end-of-frame decision of the actuator frame receiver.
// Depends on afr_pkg.
`default_nettype none

module afr_frame_core #(
	parameter int HEADER_LENGTH = afr_pkg::HEADER_LENGTH_DEF,
	parameter int RELAY_COUNT   = afr_pkg::RELAY_COUNT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire afr_pkg::afr_stage_t stage,
	input  wire logic                advance,
	input  wire logic [7:0]          room_address,
	output afr_pkg::afr_out_t        result
);
	import afr_pkg::*;

	localparam logic [7:0] HDR_LEN     = 8'(HEADER_LENGTH);
	localparam logic [7:0] DATA_OFFSET = 8'(HEADER_LENGTH + 1);
	localparam logic [7:0] RELAY_CNT   = 8'(RELAY_COUNT);

	logic [7:0] byte_count_q;
	logic       header_match_q;
	logic [7:0] data_sum_q;
	logic [7:0] length_field_q;
	logic [7:0] frame_address_q;
	logic [7:0] device_kind_q;
	logic [7:0] device_number_q;
	logic [7:0] command_code_q;
	logic [7:0] fan_request_q;
	logic [RELAY_COUNT-1:0] relay_q;
	logic [1:0]             fan_q;

	logic [7:0]             b;
	logic                   header_match_n;
	logic [7:0]             data_len;
	logic [2:0]             status;
	logic [RELAY_COUNT-1:0] relay_n;
	logic [1:0]             fan_n;
	logic [RELAY_MAX-1:0]   relay_wide;
	logic                   last_go;

	assign b       = stage.item.rx_byte;
	assign last_go = advance && stage.item.end_of_frame;

	// header compare on this byte, folded into the running match
	always_comb begin
		header_match_n = header_match_q;
		if (byte_count_q < HDR_LEN && b != HEADER_BYTES[byte_count_q[2:0]]) begin
			header_match_n = 1'b0;
		end
	end

	assign data_len = byte_count_q - DATA_OFFSET;

	// decision at frame end
	always_comb begin
		status  = ST_ACTED;
		relay_n = relay_q;
		fan_n   = fan_q;
		if (!header_match_n || byte_count_q < HDR_LEN - 8'd1) begin
			status = ST_HEADER;
		end else if (byte_count_q == COUNT_MAX || byte_count_q < DATA_OFFSET) begin
			status = ST_LENGTH;
		end else if (b != data_sum_q) begin
			status = ST_CHECKSUM;
		end else if (length_field_q != data_len || data_len < MIN_DATA) begin
			status = ST_LENGTH;
		end else if (frame_address_q != room_address) begin
			status = ST_ADDRESS;
		end else if (command_code_q != CMD_TOGGLE) begin
			status = ST_IGNORED;
		end else if (device_kind_q == KIND_RELAY) begin
			if (device_number_q == 8'd0 || device_number_q > RELAY_CNT) begin
				status = ST_IGNORED;
			end else begin
				for (int i = 0; i < RELAY_COUNT; i++) begin
					relay_n[i] = relay_q[i] ^ (device_number_q == 8'(i + 1));
				end
			end
		end else if (device_kind_q == KIND_FAN) begin
			fan_n = (fan_request_q == FAN_ON_REQ) ? 2'b11 : 2'b00;
		end else begin
			status = ST_IGNORED;
		end
	end

	assign relay_wide          = RELAY_MAX'(relay_n);
	assign result.frame_status = status;
	assign result.relay_states = relay_wide[3:0];
	assign result.fan_states   = fan_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q    <= '0;
			header_match_q  <= 1'b1;
			data_sum_q      <= '0;
			length_field_q  <= '0;
			frame_address_q <= '0;
			device_kind_q   <= '0;
			device_number_q <= '0;
			command_code_q  <= '0;
			fan_request_q   <= '0;
			relay_q         <= '0;
			fan_q           <= '0;
		end else if (advance) begin
			if (stage.item.end_of_frame) begin
				// commit actuator state, drop frame state
				relay_q         <= relay_n;
				fan_q           <= fan_n;
				byte_count_q    <= '0;
				header_match_q  <= 1'b1;
				data_sum_q      <= '0;
				length_field_q  <= '0;
				frame_address_q <= '0;
				device_kind_q   <= '0;
				device_number_q <= '0;
				command_code_q  <= '0;
				fan_request_q   <= '0;
			end else begin
				header_match_q <= header_match_n;
				if (byte_count_q == HDR_LEN)             length_field_q  <= b;
				if (byte_count_q == DATA_OFFSET)         frame_address_q <= b;
				if (byte_count_q == DATA_OFFSET + 8'd1)  device_kind_q   <= b;
				if (byte_count_q == DATA_OFFSET + 8'd2)  device_number_q <= b;
				if (byte_count_q == DATA_OFFSET + 8'd3)  command_code_q  <= b;
				if (byte_count_q == DATA_OFFSET + 8'd4)  fan_request_q   <= b;
				if (byte_count_q >= DATA_OFFSET) begin
					data_sum_q <= data_sum_q + b;
				end
				if (byte_count_q != COUNT_MAX) begin
					byte_count_q <= byte_count_q + 8'd1;
				end
			end
		end
	end

`ifndef SYNTH
	a_count_clears: assert property (@(posedge clk) disable iff (!arst_n)
		last_go |=> byte_count_q == 8'd0 && header_match_q)
		else $error("frame state not cleared at frame end");

	a_one_relay: assert property (@(posedge clk) disable iff (!arst_n)
		(last_go && status == ST_ACTED && device_kind_q == KIND_RELAY)
			|-> $onehot(relay_n ^ relay_q))
		else $error("relay toggle did not flip exactly one relay");

	a_quiet_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		(last_go && status != ST_ACTED) |=> $stable(relay_q) && $stable(fan_q))
		else $error("actuator state changed on a rejected frame");
`endif

endmodule

`default_nettype wire

[hw/rtl/actuator_frame_receiver_unit.sv]
// Top level of the actuator frame receiver: input register, frame core, result
// register and the room address register. Depends on afr_pkg, afr_in_stage, afr_frame_core.
`default_nettype none

// Actuator frame receiver. Feed received UART bytes in order on the input
// channel, one transaction per byte, with end_of_frame set on the final
// (checksum) byte. A frame is the header 41 73 75 6B 61, a length byte, at
// least five data bytes (room address, device kind, device number, command,
// fan request, then any more) and an 8-bit additive checksum over the data.
// Only the final byte of a frame produces a result transaction: frame_status
// (0 acted, 1 bad header, 2 bad checksum, 3 bad length, 4 other address,
// 5 ignored command) together with the relay and fan states after the frame.
// A valid toggle frame flips one relay or switches both fans on or off; all
// relays and fans are off after reset. Throughput is one byte per clock while
// the input is not stalled: each byte is captured in the input register and
// decided by one level of logic into the frame state or the result register,
// so a frame's result is loaded into the result register when its last byte
// advances out of the input register. The input stalls only when a finished
// result waits in the result register, the output is stalled and the byte in
// hand is another frame end. Write room_address (reset 1) over the
// configuration channel only while no frame is in flight; it is always ready.
module actuator_frame_receiver_unit #(
	parameter int HEADER_LENGTH = afr_pkg::HEADER_LENGTH_DEF,
	parameter int RELAY_COUNT   = afr_pkg::RELAY_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire afr_pkg::afr_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output afr_pkg::afr_out_t     out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [7:0]       cfg_data
);
	import afr_pkg::*;

	afr_stage_t stage;
	afr_out_t   result;
	logic       advance;
	logic       res_load;
	logic [7:0] room_address_q;
	logic       out_valid_q;
	afr_out_t   out_data_q;

	// Advance the held byte unless it is a frame end and the result slot is blocked
	assign advance  = stage.valid &&
		(!stage.item.end_of_frame || !out_valid_q || !out_stall);
	assign res_load = advance && stage.item.end_of_frame;

	afr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_data  (in_data),
		.advance  (advance),
		.in_stall (in_stall),
		.stage    (stage)
	);

	afr_frame_core #(
		.HEADER_LENGTH (HEADER_LENGTH),
		.RELAY_COUNT   (RELAY_COUNT)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.stage        (stage),
		.advance      (advance),
		.room_address (room_address_q),
		.result       (result)
	);

	// Configuration: always take the write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_address_q <= ROOM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			room_address_q <= cfg_data;
		end
	end

	// Result register: hold while stalled, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

`ifndef SYNTH
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !res_load)
		else $error("pending result overwritten");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_data_q.frame_status <= ST_IGNORED)
		else $error("frame status out of range");
`endif

endmodule

`default_nettype wire
